### sv/rfc_pkg.sv
// Shared types, constants and character helpers for the reply frame checker.
package rfc_pkg;

  localparam int unsigned ByteW = 8;
  localparam int unsigned CodeW = 7;

  localparam logic [ByteW-1:0] TermReset = 8'h06;

  // Frame status codes carried on frame_status.
  typedef enum logic [1:0] {
    ST_OK  = 2'd0,
    ST_SUM = 2'd1,
    ST_ERR = 2'd2,
    ST_BAD = 2'd3
  } rfc_status_e;

  // Outcome of one frame, passed from the front to the back.
  typedef struct packed {
    rfc_status_e            status;
    logic [CodeW-1:0]       code;
    logic                   has_payload;
    logic                   bank;
  } rfc_verdict_t;

  // Back tells the front that a payload bank has been fully read.
  typedef struct packed {
    logic valid;
    logic bank;
  } rfc_release_t;

  typedef struct packed {
    logic       ok;
    logic [3:0] val;
  } rfc_hex_t;

  // Decodes one upper or lower case hex digit.
  function automatic rfc_hex_t hex_value(input logic [ByteW-1:0] c);
    rfc_hex_t r;
    r.ok  = 1'b1;
    r.val = 4'd0;
    if (c >= 8'h30 && c <= 8'h39) begin
      r.val = c[3:0];
    end else if ((c >= 8'h41 && c <= 8'h46) || (c >= 8'h61 && c <= 8'h66)) begin
      r.val = c[3:0] + 4'd9;
    end else begin
      r.ok = 1'b0;
    end
    return r;
  endfunction

  function automatic logic is_digit(input logic [ByteW-1:0] c);
    return (c >= 8'h30) && (c <= 8'h39);
  endfunction

endpackage

### sv/rfc_ram.sv
// Generic single-write, single-read RAM with a registered read port.
module rfc_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 32
) (
  input  logic                     clk_i,
  input  logic                     we_i,
  input  logic [$clog2(Depth)-1:0] waddr_i,
  input  logic [Width-1:0]         wdata_i,
  input  logic                     re_i,
  input  logic [$clog2(Depth)-1:0] raddr_i,
  output logic [Width-1:0]         rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  // Write port.
  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
  end

  // Registered read port; the data holds until the next read.
  always_ff @(posedge clk_i) begin
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

### sv/rfc_fifo.sv
// Two-entry request queue between the frame front and the result back.
module rfc_fifo #(
  parameter int unsigned Width = 8
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             push_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             pop_i,
  output logic [Width-1:0] rdata_o,
  output logic             empty_o,
  output logic             full_o
);

  logic [Width-1:0] slot_q [2];
  logic             wptr_q, wptr_d;
  logic             rptr_q, rptr_d;
  logic [1:0]       count_q, count_d;

  assign empty_o = (count_q == 2'd0);
  assign full_o  = (count_q == 2'd2);
  assign rdata_o = slot_q[rptr_q];

  // Pointer and fill bookkeeping.
  always_comb begin
    wptr_d  = wptr_q;
    rptr_d  = rptr_q;
    count_d = count_q;
    if (push_i) begin
      wptr_d = ~wptr_q;
    end
    if (pop_i) begin
      rptr_d = ~rptr_q;
    end
    if (push_i && !pop_i) begin
      count_d = count_q + 2'd1;
    end else if (pop_i && !push_i) begin
      count_d = count_q - 2'd1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wptr_q  <= 1'b0;
      rptr_q  <= 1'b0;
      count_q <= 2'd0;
    end else begin
      wptr_q  <= wptr_d;
      rptr_q  <= rptr_d;
      count_q <= count_d;
    end
  end

  // Entry storage.
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      slot_q[wptr_q] <= wdata_i;
    end
  end

endmodule

### sv/rfc_front.sv
// Frame front: collects line bytes, stores payload and judges each frame.
module rfc_front import rfc_pkg::*; #(
  parameter int unsigned MaxPayload = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            cfg_we_i,
  input  logic [ByteW-1:0]                terminator_char_i,
  input  logic                            in_valid_i,
  output logic                            in_stall_o,
  input  logic [ByteW-1:0]                line_byte_i,
  output logic                            ram_we_o,
  output logic [$clog2(MaxPayload):0]     ram_waddr_o,
  output logic [ByteW-1:0]                ram_wdata_o,
  output logic                            push_o,
  output rfc_verdict_t                    verdict_o,
  output logic [$clog2(MaxPayload+1)-1:0] len_o,
  input  logic                            fifo_full_i,
  input  rfc_release_t                    release_i
);

  localparam int unsigned PosCap = MaxPayload + 7;
  localparam int unsigned PosW   = $clog2(PosCap + 1);
  localparam int unsigned SlotW  = $clog2(MaxPayload);
  localparam int unsigned LenW   = $clog2(MaxPayload + 1);

  logic [ByteW-1:0] term_q;
  logic [PosW-1:0]  pos_q, pos_d;
  logic [ByteW-1:0] sum_q, sum_d;
  logic [ByteW-1:0] t0_q, t0_d, t1_q, t1_d;
  logic             ovf_q, ovf_d;
  logic             bank_q, bank_d;
  logic [1:0]       busy_q, busy_d;

  logic             accept;
  logic             is_term;
  logic [PosW-1:0]  slot;
  rfc_hex_t         hex_hi, hex_lo;
  logic [CodeW-1:0] d1, d2, code;

  // A bank still being read by the back holds off all new bytes.
  assign in_stall_o = busy_q[bank_q] || fifo_full_i;
  assign accept     = in_valid_i && !in_stall_o;
  assign is_term    = (line_byte_i == term_q);
  assign slot       = pos_q - PosW'(6);

  // Terminator register.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      term_q <= TermReset;
    end else if (cfg_we_i) begin
      term_q <= terminator_char_i;
    end
  end

  // Error reply code from the two trailing decimal digits, or from the first alone if the second is no digit.
  always_comb begin
    d1 = {3'b000, t0_q[3:0]};
    d2 = {3'b000, t1_q[3:0]};
    code = '0;
    if (is_digit(t0_q)) begin
      if (is_digit(t1_q)) begin
        code = (d1 << 3) + (d1 << 1) + d2;
      end else begin
        code = d1;
      end
    end
  end

  assign hex_hi = hex_value(t0_q);
  assign hex_lo = hex_value(t1_q);

  // Frame verdict, valid on the terminator request.
  always_comb begin
    verdict_o.status      = ST_OK;
    verdict_o.code        = '0;
    verdict_o.has_payload = 1'b0;
    verdict_o.bank        = bank_q;
    len_o                 = '0;
    if (pos_q < PosW'(6) || ovf_q) begin
      verdict_o.status = ST_BAD;
    end else if (pos_q == PosW'(7)) begin
      verdict_o.status = ST_ERR;
      verdict_o.code   = code;
    end else if (!hex_hi.ok || !hex_lo.ok || ({hex_hi.val, hex_lo.val} != sum_q)) begin
      verdict_o.status = ST_SUM;
    end else begin
      verdict_o.has_payload = (pos_q != PosW'(6));
      len_o                 = LenW'(slot);
    end
  end

  assign push_o = accept && is_term;

  // Frame collection: the byte two places back joins the sum and the store.
  always_comb begin
    pos_d       = pos_q;
    sum_d       = sum_q;
    t0_d        = t0_q;
    t1_d        = t1_q;
    ovf_d       = ovf_q;
    bank_d      = bank_q;
    ram_we_o    = 1'b0;
    ram_waddr_o = {bank_q, slot[SlotW-1:0]};
    ram_wdata_o = t0_q;
    if (accept) begin
      if (is_term) begin
        pos_d  = '0;
        sum_d  = '0;
        t0_d   = '0;
        t1_d   = '0;
        ovf_d  = 1'b0;
        bank_d = ~bank_q;
      end else begin
        if (pos_q >= PosW'(3)) begin
          sum_d = sum_q + t0_q;
          if (pos_q >= PosW'(6)) begin
            if (slot < PosW'(MaxPayload)) begin
              ram_we_o = 1'b1;
            end else begin
              ovf_d = 1'b1;
            end
          end
        end
        t0_d = t1_q;
        t1_d = line_byte_i;
        if (pos_q != PosW'(PosCap)) begin
          pos_d = pos_q + PosW'(1);
        end
      end
    end
  end

  // Bank busy flags: set by a payload frame, cleared when the back is done.
  always_comb begin
    busy_d = busy_q;
    if (release_i.valid) begin
      busy_d[release_i.bank] = 1'b0;
    end
    if (push_o && verdict_o.has_payload) begin
      busy_d[bank_q] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q  <= '0;
      sum_q  <= '0;
      t0_q   <= '0;
      t1_q   <= '0;
      ovf_q  <= 1'b0;
      bank_q <= 1'b0;
      busy_q <= '0;
    end else begin
      pos_q  <= pos_d;
      sum_q  <= sum_d;
      t0_q   <= t0_d;
      t1_q   <= t1_d;
      ovf_q  <= ovf_d;
      bank_q <= bank_d;
      busy_q <= busy_d;
    end
  end

endmodule

### sv/rfc_back.sv
// Result back: turns queued frame verdicts into result requests.
module rfc_back import rfc_pkg::*; #(
  parameter int unsigned MaxPayload = 16
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            fifo_empty_i,
  input  rfc_verdict_t                    verdict_i,
  input  logic [$clog2(MaxPayload+1)-1:0] len_i,
  output logic                            pop_o,
  output logic                            ram_re_o,
  output logic [$clog2(MaxPayload):0]     ram_raddr_o,
  input  logic [ByteW-1:0]                ram_rdata_i,
  output rfc_release_t                    release_o,
  output logic                            out_valid_o,
  input  logic                            out_stall_i,
  output logic [ByteW-1:0]                payload_byte_o,
  output logic                            byte_valid_o,
  output logic [1:0]                      frame_status_o,
  output logic [CodeW-1:0]                error_code_o,
  output logic                            last_o
);

  localparam int unsigned SlotW = $clog2(MaxPayload);
  localparam int unsigned LenW  = $clog2(MaxPayload + 1);

  typedef enum logic [3:0] {
    B_IDLE   = 4'b0001,
    B_SINGLE = 4'b0010,
    B_READ   = 4'b0100,
    B_LOAD   = 4'b1000
  } back_state_e;

  back_state_e      state_q, state_d;
  rfc_verdict_t     job_q, job_d;
  logic [LenW-1:0]  len_q, len_d;
  logic [SlotW-1:0] idx_q, idx_d;

  logic             out_valid_q, out_valid_d;
  logic [ByteW-1:0] byte_q, byte_d;
  logic             bvalid_q, bvalid_d;
  rfc_status_e      status_q, status_d;
  logic [CodeW-1:0] code_q, code_d;
  logic             last_q, last_d;

  logic             out_free;
  logic             is_last;

  assign out_free    = !out_valid_q || !out_stall_i;
  assign is_last     = ((LenW'(idx_q) + LenW'(1)) == len_q);
  assign ram_raddr_o = {job_q.bank, idx_q};

  // Sequencer over the queued verdicts and the payload reads.
  always_comb begin
    state_d     = state_q;
    job_d       = job_q;
    len_d       = len_q;
    idx_d       = idx_q;
    pop_o       = 1'b0;
    ram_re_o    = 1'b0;
    release_o   = '{valid: 1'b0, bank: job_q.bank};
    out_valid_d = out_valid_q && out_stall_i;
    byte_d      = byte_q;
    bvalid_d    = bvalid_q;
    status_d    = status_q;
    code_d      = code_q;
    last_d      = last_q;
    unique case (state_q)
      B_IDLE: begin
        if (!fifo_empty_i) begin
          pop_o   = 1'b1;
          job_d   = verdict_i;
          len_d   = len_i;
          idx_d   = '0;
          state_d = verdict_i.has_payload ? B_READ : B_SINGLE;
        end
      end
      B_SINGLE: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          byte_d      = '0;
          bvalid_d    = 1'b0;
          status_d    = job_q.status;
          code_d      = job_q.code;
          last_d      = 1'b1;
          state_d     = B_IDLE;
        end
      end
      B_READ: begin
        ram_re_o = 1'b1;
        state_d  = B_LOAD;
      end
      B_LOAD: begin
        if (out_free) begin
          out_valid_d = 1'b1;
          byte_d      = ram_rdata_i;
          bvalid_d    = 1'b1;
          status_d    = ST_OK;
          code_d      = '0;
          last_d      = is_last;
          if (is_last) begin
            release_o.valid = 1'b1;
            state_d         = B_IDLE;
          end else begin
            idx_d   = idx_q + SlotW'(1);
            state_d = B_READ;
          end
        end
      end
      default: begin
        state_d = B_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= B_IDLE;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      out_valid_q <= out_valid_d;
    end
  end

  // Job and output payload registers.
  always_ff @(posedge clk_i) begin
    job_q    <= job_d;
    len_q    <= len_d;
    idx_q    <= idx_d;
    byte_q   <= byte_d;
    bvalid_q <= bvalid_d;
    status_q <= status_d;
    code_q   <= code_d;
    last_q   <= last_d;
  end

  assign out_valid_o    = out_valid_q;
  assign payload_byte_o = byte_q;
  assign byte_valid_o   = bvalid_q;
  assign frame_status_o = status_q;
  assign error_code_o   = code_q;
  assign last_o         = last_q;

endmodule

### sv/reply_frame_checker.sv
// A non-terminator line byte is taken and gives no result. A terminator's verdict
// passes through the verdict queue and the back's sequencer to the registered outputs;
// with payload, each byte follows its own registered payload RAM read, one at a time.
// Throughput: one line byte per cycle, except while the verdict queue is full or the
// payload bank the next frame needs is still being read.
// Reset clears all control state and sets the terminator to 0x06; RAM contents stay undefined.
module reply_frame_checker import rfc_pkg::*; #(
  parameter int unsigned MaxPayload = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [ByteW-1:0]   terminator_char_i,
  input  logic               in_valid_i,
  output logic               in_stall_o,
  input  logic [ByteW-1:0]   line_byte_i,
  output logic               out_valid_o,
  input  logic               out_stall_i,
  output logic [ByteW-1:0]   payload_byte_o,
  output logic               byte_valid_o,
  output logic [1:0]         frame_status_o,
  output logic [CodeW-1:0]   error_code_o,
  output logic               last_o
);

  localparam int unsigned SlotW  = $clog2(MaxPayload);
  localparam int unsigned AddrW  = SlotW + 1;
  localparam int unsigned LenW   = $clog2(MaxPayload + 1);
  localparam int unsigned QueueW = $bits(rfc_verdict_t) + LenW;

  logic               ram_we;
  logic [AddrW-1:0]   ram_waddr;
  logic [ByteW-1:0]   ram_wdata;
  logic               ram_re;
  logic [AddrW-1:0]   ram_raddr;
  logic [ByteW-1:0]   ram_rdata;

  logic               push, pop, q_empty, q_full;
  rfc_verdict_t       front_verdict, back_verdict;
  logic [LenW-1:0]    front_len, back_len;
  rfc_release_t       bank_release;

  // Frame collection and verdict.
  rfc_front #(
    .MaxPayload (MaxPayload)
  ) u_front (
    .clk_i             (clk_i),
    .rst_ni            (rst_ni),
    .cfg_we_i          (cfg_we_i),
    .terminator_char_i (terminator_char_i),
    .in_valid_i        (in_valid_i),
    .in_stall_o        (in_stall_o),
    .line_byte_i       (line_byte_i),
    .ram_we_o          (ram_we),
    .ram_waddr_o       (ram_waddr),
    .ram_wdata_o       (ram_wdata),
    .push_o            (push),
    .verdict_o         (front_verdict),
    .len_o             (front_len),
    .fifo_full_i       (q_full),
    .release_i         (bank_release)
  );

  // Payload store, one bank per frame in flight.
  rfc_ram #(
    .Width (ByteW),
    .Depth (2 << SlotW)
  ) u_ram (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  // Verdict queue.
  rfc_fifo #(
    .Width (QueueW)
  ) u_fifo (
    .clk_i   (clk_i),
    .rst_ni  (rst_ni),
    .push_i  (push),
    .wdata_i ({front_verdict, front_len}),
    .pop_i   (pop),
    .rdata_o ({back_verdict, back_len}),
    .empty_o (q_empty),
    .full_o  (q_full)
  );

  // Result generation.
  rfc_back #(
    .MaxPayload (MaxPayload)
  ) u_back (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .fifo_empty_i   (q_empty),
    .verdict_i      (back_verdict),
    .len_i          (back_len),
    .pop_o          (pop),
    .ram_re_o       (ram_re),
    .ram_raddr_o    (ram_raddr),
    .ram_rdata_i    (ram_rdata),
    .release_o      (bank_release),
    .out_valid_o    (out_valid_o),
    .out_stall_i    (out_stall_i),
    .payload_byte_o (payload_byte_o),
    .byte_valid_o   (byte_valid_o),
    .frame_status_o (frame_status_o),
    .error_code_o   (error_code_o),
    .last_o         (last_o)
  );

endmodule
